// ===== src/rrtt_pkg.sv =====
package rrtt_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam logic [2:0] ST_UNUSED  = 3'd0;
    localparam logic [2:0] ST_READY   = 3'd1;
    localparam logic [2:0] ST_RUNNING = 3'd2;
    localparam logic [2:0] ST_BLOCKED = 3'd3;
    localparam logic [2:0] ST_DEAD    = 3'd4;

    localparam logic [2:0] REQ_CREATE  = 3'd0;
    localparam logic [2:0] REQ_SET     = 3'd1;
    localparam logic [2:0] REQ_DISPATCH = 3'd2;
    localparam logic [2:0] REQ_REAP    = 3'd3;
    localparam logic [2:0] REQ_WAKE    = 3'd4;
    localparam logic [2:0] REQ_UNBLOCK = 3'd5;
    localparam logic [2:0] REQ_BLOCK   = 3'd6;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NO_FREE = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    localparam logic [2:0] REAP_GRACE_RESET = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } fsm_t;

endpackage

// ===== src/rrtt_if.sv =====
interface rrtt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] task_id;
    logic [2:0]  new_state;
    logic        has_entry;
    logic [47:0] now_ms;
    logic [47:0] wake_ms;

    modport source (output valid, req_type, task_id, new_state, has_entry, now_ms, wake_ms,
                    input ready);
    modport sink   (input valid, req_type, task_id, new_state, has_entry, now_ms, wake_ms,
                    output ready);
endinterface

interface rrtt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] id_out;
    logic [3:0]  slot_out;
    logic [31:0] woken_count;

    modport source (output valid, status, id_out, slot_out, woken_count, input ready);
    modport sink   (input valid, status, id_out, slot_out, woken_count, output ready);
endinterface

// ===== src/round_robin_task_table_top.sv =====
// Round-robin task table.
// Requests arrive on req (valid/ready); each gives exactly one transaction on rsp.
// A request is taken only when the block is idle. It then walks the slot table
// one slot per cycle through a single shared compare unit, then raises rsp.valid.
// The response is held in an output register until rsp.ready; no new request
// is accepted meanwhile. reap_grace is written by cfg_we/cfg_data (low 3 bits);
// the user must write it only while idle, as the block does not enforce this.
// Reset (rst_n low, asynchronous) empties the table, clears the current slot,
// sets the next id to 1, woken count to 0 and reap_grace to 4.
module round_robin_task_table_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_data,
    rrtt_req_if.sink   req,
    rrtt_rsp_if.source rsp
);
    localparam int SW = rrtt_pkg::SLOT_W;
    localparam int N  = rrtt_pkg::SLOTS;

    // slot table
    logic [2:0]  st_reg   [N];
    logic [31:0] id_reg   [N];
    logic [47:0] wake_reg [N];
    logic [2:0]  age_reg  [N];
    logic        ent_reg  [N];
    logic [31:0] disp_reg [N];

    rrtt_pkg::fsm_t state_reg, state_next;
    logic [SW:0]  cnt_reg;
    logic [SW-1:0] idx_reg;
    logic         cur_valid_reg;
    logic [SW-1:0] cur_reg;
    logic [31:0]  next_id_reg, woken_reg;
    logic [2:0]   grace_reg;
    logic         done_reg;
    // latched request
    logic [2:0]  rq_type_reg;
    logic [31:0] rq_id_reg;
    logic [2:0]  rq_nst_reg;
    logic        rq_ent_reg;
    logic [47:0] rq_now_reg, rq_wk_reg;
    // response
    logic [1:0]  stat_reg;
    logic [31:0] ido_reg;
    logic [3:0]  sloto_reg;

    // shared compare unit on the visited slot
    logic [2:0]  cs;
    logic        id_hit, wake_hit;
    always_comb
    begin
        cs = st_reg[idx_reg];
        id_hit = (rq_id_reg != 32'd0) && (id_reg[idx_reg] == rq_id_reg);
        wake_hit = (cs == rrtt_pkg::ST_BLOCKED) && (wake_reg[idx_reg] != 48'd0)
                   && (rq_now_reg >= wake_reg[idx_reg]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrtt_pkg::S_IDLE: if (req.valid) state_next = rrtt_pkg::S_SCAN;
            rrtt_pkg::S_SCAN: if (cnt_reg == (SW+1)'(N - 1)) state_next = rrtt_pkg::S_OUT;
            rrtt_pkg::S_OUT:  if (rsp.ready) state_next = rrtt_pkg::S_IDLE;
            default:          state_next = rrtt_pkg::S_IDLE;
        endcase
    end

    assign req.ready = (state_reg == rrtt_pkg::S_IDLE);
    assign rsp.valid = (state_reg == rrtt_pkg::S_OUT);
    assign rsp.status = stat_reg;
    assign rsp.id_out = ido_reg;
    assign rsp.slot_out = sloto_reg;
    assign rsp.woken_count = woken_reg;

    // control and scan sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrtt_pkg::S_IDLE;
            cnt_reg <= '0;
            idx_reg <= '0;
            cur_valid_reg <= 1'b0;
            cur_reg <= '0;
            next_id_reg <= 32'd1;
            woken_reg <= '0;
            grace_reg <= rrtt_pkg::REAP_GRACE_RESET;
            done_reg <= 1'b0;
            rq_type_reg <= '0;
            rq_id_reg <= '0;
            rq_nst_reg <= '0;
            rq_ent_reg <= 1'b0;
            rq_now_reg <= '0;
            rq_wk_reg <= '0;
            stat_reg <= rrtt_pkg::STAT_DONE;
            ido_reg <= '0;
            sloto_reg <= '0;
            for (int i = 0; i < N; i++)
            begin
                st_reg[i] <= rrtt_pkg::ST_UNUSED;
                id_reg[i] <= '0;
                wake_reg[i] <= '0;
                age_reg[i] <= '0;
                ent_reg[i] <= 1'b0;
                disp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) grace_reg <= cfg_data;
            if (state_reg == rrtt_pkg::S_IDLE && req.valid)
            begin
                rq_type_reg <= req.req_type;
                rq_id_reg <= req.task_id;
                rq_nst_reg <= req.new_state;
                rq_ent_reg <= req.has_entry;
                rq_now_reg <= req.now_ms;
                rq_wk_reg <= req.wake_ms;
                cnt_reg <= '0;
                done_reg <= 1'b0;
                ido_reg <= '0;
                sloto_reg <= '0;
                if (req.req_type == rrtt_pkg::REQ_DISPATCH)
                    idx_reg <= cur_valid_reg ? cur_reg + SW'(1) : '0;
                else
                    idx_reg <= '0;
                case (req.req_type) inside
                    rrtt_pkg::REQ_CREATE: stat_reg <= rrtt_pkg::STAT_NO_FREE;
                    rrtt_pkg::REQ_SET, rrtt_pkg::REQ_DISPATCH, rrtt_pkg::REQ_UNBLOCK,
                    rrtt_pkg::REQ_BLOCK: stat_reg <= rrtt_pkg::STAT_NOT_FOUND;
                    default: stat_reg <= rrtt_pkg::STAT_DONE;
                endcase
                if (req.req_type == rrtt_pkg::REQ_DISPATCH && !cur_valid_reg)
                begin
                    cur_valid_reg <= 1'b1;
                    cur_reg <= SW'(N - 1);
                end
            end
            else if (state_reg == rrtt_pkg::S_SCAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                idx_reg <= idx_reg + SW'(1);
                case (rq_type_reg) inside
                    rrtt_pkg::REQ_CREATE:
                        if (!done_reg && (cs == rrtt_pkg::ST_UNUSED || cs == rrtt_pkg::ST_DEAD))
                        begin
                            done_reg <= 1'b1;
                            st_reg[idx_reg] <= rrtt_pkg::ST_READY;
                            id_reg[idx_reg] <= next_id_reg;
                            wake_reg[idx_reg] <= '0;
                            ent_reg[idx_reg] <= rq_ent_reg;
                            disp_reg[idx_reg] <= '0;
                            next_id_reg <= next_id_reg + 32'd1;
                            stat_reg <= rrtt_pkg::STAT_DONE;
                            ido_reg <= next_id_reg;
                            sloto_reg <= 4'(idx_reg);
                        end
                    rrtt_pkg::REQ_SET, rrtt_pkg::REQ_BLOCK:
                        if (!done_reg && id_hit)
                        begin
                            done_reg <= 1'b1;
                            if (rq_type_reg == rrtt_pkg::REQ_BLOCK)
                            begin
                                st_reg[idx_reg] <= rrtt_pkg::ST_BLOCKED;
                                wake_reg[idx_reg] <= rq_wk_reg;
                                stat_reg <= rrtt_pkg::STAT_DONE;
                            end
                            else if (rq_nst_reg <= rrtt_pkg::ST_DEAD)
                            begin
                                st_reg[idx_reg] <= rq_nst_reg;
                                stat_reg <= rrtt_pkg::STAT_DONE;
                            end
                        end
                    rrtt_pkg::REQ_DISPATCH:
                        if (!done_reg && cs == rrtt_pkg::ST_READY)
                        begin
                            done_reg <= 1'b1;
                            cur_valid_reg <= 1'b1;
                            cur_reg <= idx_reg;
                            if (ent_reg[idx_reg])
                                disp_reg[idx_reg] <= disp_reg[idx_reg] + 32'd1;
                            stat_reg <= rrtt_pkg::STAT_DONE;
                            ido_reg <= id_reg[idx_reg];
                            sloto_reg <= 4'(idx_reg);
                        end
                    rrtt_pkg::REQ_REAP:
                        if (cs != rrtt_pkg::ST_DEAD)
                            age_reg[idx_reg] <= '0;
                        else if (age_reg[idx_reg] < grace_reg)
                            age_reg[idx_reg] <= age_reg[idx_reg] + 3'd1;
                        else
                        begin
                            st_reg[idx_reg] <= rrtt_pkg::ST_UNUSED;
                            id_reg[idx_reg] <= '0;
                            wake_reg[idx_reg] <= '0;
                            ent_reg[idx_reg] <= 1'b0;
                            disp_reg[idx_reg] <= '0;
                            age_reg[idx_reg] <= '0;
                        end
                    rrtt_pkg::REQ_WAKE:
                        if (wake_hit)
                        begin
                            wake_reg[idx_reg] <= '0;
                            st_reg[idx_reg] <= rrtt_pkg::ST_READY;
                            woken_reg <= woken_reg + 32'd1;
                        end
                    rrtt_pkg::REQ_UNBLOCK:
                        if (id_hit && cs == rrtt_pkg::ST_BLOCKED)
                        begin
                            st_reg[idx_reg] <= rrtt_pkg::ST_READY;
                            stat_reg <= rrtt_pkg::STAT_DONE;
                        end
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== verif/rrtt_tb_if.sv =====
`timescale 1ns / 1ps

// Request transaction as held in the driver's pending queue
package rrtt_tb_pkg;
    // request type and state code outside the defined sets
    localparam logic [2:0] REQ_RESERVED = 3'd7;
    localparam logic [2:0] ST_BAD_CODE  = 3'd7;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] task_id;
        logic [2:0]  new_state;
        logic        has_entry;
        logic [47:0] now_ms;
        logic [47:0] wake_ms;
        logic        is_cfg;     // not a request: write reap_grace once idle
        logic [2:0]  cfg_value;
    } sched_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] id_out;
        logic [3:0]  slot_out;
        logic [31:0] woken_count;
    } sched_rsp_t;
endpackage

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    localparam int NUM_RANDOM = 1950;
    localparam int SLOTS = rrtt_pkg::SLOTS;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_data;

    rrtt_req_if req_ch ();
    rrtt_rsp_if rsp_ch ();

    round_robin_task_table_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch.sink),
        .rsp      (rsp_ch.source)
    );

    // Scheduler state mirror
    logic [2:0]  tbl_state [SLOTS];
    logic [31:0] tbl_id    [SLOTS];
    logic [47:0] tbl_wake  [SLOTS];
    logic [2:0]  tbl_age   [SLOTS];
    logic        tbl_entry [SLOTS];
    logic [31:0] tbl_disp  [SLOTS];
    logic        cur_valid;
    logic [3:0]  cur_slot;
    logic [31:0] id_counter;
    logic [31:0] wake_total;
    logic [2:0]  grace;

    rrtt_tb_pkg::sched_req_t pending_q [$];
    rrtt_tb_pkg::sched_rsp_t expected_q [$];
    int  mismatches = 0;
    bit  quiet;         // no idling in the final stretch

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int first_with_id(logic [31:0] id);
        if (id == 0)
            return -1;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void clear_entry(int i);
        tbl_state[i] = rrtt_pkg::ST_UNUSED;
        tbl_id[i]    = '0;
        tbl_wake[i]  = '0;
        tbl_entry[i] = 1'b0;
        tbl_disp[i]  = '0;
    endfunction

    // Mirror state after reset
    function automatic void reset_mirror();
        for (int i = 0; i < SLOTS; i++)
        begin
            clear_entry(i);
            tbl_age[i] = '0;
        end
        cur_valid  = 1'b0;
        cur_slot   = '0;
        id_counter = 32'd1;
        wake_total = '0;
        grace      = rrtt_pkg::REAP_GRACE_RESET;
    endfunction

    // Works out the response to one request and updates the mirror
    function automatic rrtt_tb_pkg::sched_rsp_t schedule_step(rrtt_tb_pkg::sched_req_t r);
        rrtt_tb_pkg::sched_rsp_t o;
        int s;
        int idx;
        bit found;
        o = '0;
        case (r.req_type)
            rrtt_pkg::REQ_CREATE:
            begin
                o.status = rrtt_pkg::STAT_NO_FREE;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_state[i] == rrtt_pkg::ST_UNUSED || tbl_state[i] == rrtt_pkg::ST_DEAD)
                    begin
                        clear_entry(i);
                        tbl_id[i]    = id_counter;
                        id_counter   = id_counter + 32'd1;
                        tbl_entry[i] = r.has_entry;
                        tbl_state[i] = rrtt_pkg::ST_READY;
                        o.status     = rrtt_pkg::STAT_DONE;
                        o.id_out     = tbl_id[i];
                        o.slot_out   = 4'(i);
                        break;
                    end
                end
            end
            rrtt_pkg::REQ_SET:
            begin
                s = first_with_id(r.task_id);
                if (s < 0 || r.new_state > rrtt_pkg::ST_DEAD)
                    o.status = rrtt_pkg::STAT_NOT_FOUND;
                else
                    tbl_state[s] = r.new_state;
            end
            rrtt_pkg::REQ_DISPATCH:
            begin
                idx = cur_valid ? int'(cur_slot) : SLOTS - 1;
                found = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    idx = (idx + 1) % SLOTS;
                    if (tbl_state[idx] == rrtt_pkg::ST_READY)
                    begin
                        found = 1;
                        break;
                    end
                end
                cur_valid = 1'b1;
                cur_slot  = 4'(idx);
                if (found)
                begin
                    if (tbl_entry[idx])
                        tbl_disp[idx] = tbl_disp[idx] + 32'd1;
                    o.id_out   = tbl_id[idx];
                    o.slot_out = 4'(idx);
                end
                else
                    o.status = rrtt_pkg::STAT_NOT_FOUND;
            end
            rrtt_pkg::REQ_REAP:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_state[i] != rrtt_pkg::ST_DEAD)
                        tbl_age[i] = '0;
                    else if (tbl_age[i] < grace)
                        tbl_age[i] = tbl_age[i] + 3'd1;
                    else
                    begin
                        clear_entry(i);
                        tbl_age[i] = '0;
                    end
                end
            end
            rrtt_pkg::REQ_WAKE:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_state[i] == rrtt_pkg::ST_BLOCKED && tbl_wake[i] != 0
                        && r.now_ms >= tbl_wake[i])
                    begin
                        tbl_wake[i]  = '0;
                        tbl_state[i] = rrtt_pkg::ST_READY;
                        wake_total   = wake_total + 32'd1;
                    end
                end
            end
            rrtt_pkg::REQ_UNBLOCK:
            begin
                o.status = rrtt_pkg::STAT_NOT_FOUND;
                if (r.task_id != 0)
                    for (int i = 0; i < SLOTS; i++)
                        if (tbl_id[i] == r.task_id && tbl_state[i] == rrtt_pkg::ST_BLOCKED)
                        begin
                            tbl_state[i] = rrtt_pkg::ST_READY;
                            o.status     = rrtt_pkg::STAT_DONE;
                        end
            end
            rrtt_pkg::REQ_BLOCK:
            begin
                s = first_with_id(r.task_id);
                if (s < 0)
                    o.status = rrtt_pkg::STAT_NOT_FOUND;
                else
                begin
                    tbl_state[s] = rrtt_pkg::ST_BLOCKED;
                    tbl_wake[s]  = r.wake_ms;
                end
            end
            default: ;
        endcase
        o.woken_count = wake_total;
        return o;
    endfunction

    // Picks an id: mostly a live one, sometimes zero or arbitrary
    function automatic logic [31:0] pick_id();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return '0;
        if (k == 1)
            return $urandom;
        if (k == 2)
            return id_counter + 32'($urandom_range(0, 2));
        return id_counter - 32'($urandom_range(1, 20));
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Builds one request transaction
    function automatic rrtt_tb_pkg::sched_req_t make_req(logic [2:0] t, logic [31:0] id,
                                                        logic [2:0] ns, logic ent,
                                                        logic [47:0] now, logic [47:0] wk);
        rrtt_tb_pkg::sched_req_t r;
        r = '0;
        r.req_type  = t;
        r.task_id   = id;
        r.new_state = ns;
        r.has_entry = ent;
        r.now_ms    = now;
        r.wake_ms   = wk;
        return r;
    endfunction

    function automatic rrtt_tb_pkg::sched_req_t cfg_item(logic [2:0] v);
        rrtt_tb_pkg::sched_req_t r;
        r = '0;
        r.is_cfg    = 1'b1;
        r.cfg_value = v;
        return r;
    endfunction

    // Driver: one pending entry at a time; configuration waits for idle
    int idle_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            cfg_we       <= 1'b0;
            cfg_data     <= '0;
            idle_left    = 0;
            reset_mirror();
        end
        else
        begin
            cfg_we <= 1'b0;
            if (req_ch.valid && req_ch.ready)
            begin
                expected_q.push_back(schedule_step(pending_q.pop_front()));
            end
            if (req_ch.valid && !req_ch.ready)
                ;   // hold
            else if (pending_q.size() != 0)
            begin
                if (pending_q[0].is_cfg)
                begin
                    req_ch.valid <= 1'b0;
                    if (expected_q.size() == 0 && !(req_ch.valid && req_ch.ready)
                        && !rsp_ch.valid)
                    begin
                        cfg_we   <= 1'b1;
                        cfg_data <= pending_q[0].cfg_value;
                        grace     = pending_q[0].cfg_value;
                        void'(pending_q.pop_front());
                    end
                end
                else if (!quiet && idle_left > 0)
                begin
                    idle_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    // start an idle burst
                    idle_left = $urandom_range(0, 8);
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    req_ch.valid     <= 1'b1;
                    req_ch.req_type  <= pending_q[0].req_type;
                    req_ch.task_id   <= pending_q[0].task_id;
                    req_ch.new_state <= pending_q[0].new_state;
                    req_ch.has_entry <= pending_q[0].has_entry;
                    req_ch.now_ms    <= pending_q[0].now_ms;
                    req_ch.wake_ms   <= pending_q[0].wake_ms;
                end
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Monitor: compares each response transaction with the oldest expectation
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: status %0d id %0d slot %0d",
                                 rsp_ch.status, rsp_ch.id_out, rsp_ch.slot_out);
                end
                else
                begin
                    rrtt_tb_pkg::sched_rsp_t e;
                    e = expected_q.pop_front();
                    if (rsp_ch.status !== e.status || rsp_ch.id_out !== e.id_out
                        || rsp_ch.slot_out !== e.slot_out
                        || rsp_ch.woken_count !== e.woken_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp st %0d id %0d slot %0d woken %0d,",
                                      " got st %0d id %0d slot %0d woken %0d"},
                                     e.status, e.id_out, e.slot_out, e.woken_count,
                                     rsp_ch.status, rsp_ch.id_out, rsp_ch.slot_out,
                                     rsp_ch.woken_count);
                    end
                end
            end
            // random stall bursts
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Stimulus
    task automatic queue_req(rrtt_tb_pkg::sched_req_t r);
        pending_q.push_back(r);
    endtask

    initial
    begin
        logic [2:0] t;
        int k;
        quiet = 0;

        // Directed: dispatch on empty table, fill beyond full, each request kind
        queue_req(make_req(rrtt_pkg::REQ_DISPATCH, '0, '0, 1'b0, '0, '0));
        for (int i = 0; i < SLOTS + 1; i++)
            queue_req(make_req(rrtt_pkg::REQ_CREATE, '0, '0, 1'(i), '0, '0));
        queue_req(make_req(rrtt_pkg::REQ_SET, 32'd2, rrtt_pkg::ST_DEAD, 1'b0, '0, '0));
        queue_req(make_req(rrtt_pkg::REQ_SET, 32'd3, rrtt_tb_pkg::ST_BAD_CODE, 1'b0,
                           '0, '0));
        queue_req(make_req(rrtt_pkg::REQ_SET, '0, rrtt_pkg::ST_READY, 1'b0, '0, '0));
        queue_req(make_req(rrtt_pkg::REQ_BLOCK, 32'd4, '0, 1'b0, '0, 48'hFFFF_FFFF_FFFF));
        queue_req(make_req(rrtt_pkg::REQ_BLOCK, 32'd5, '0, 1'b0, '0, '0));
        queue_req(make_req(rrtt_pkg::REQ_WAKE, '0, '0, 1'b0, 48'hFFFF_FFFF_FFFF, '0));
        queue_req(make_req(rrtt_pkg::REQ_UNBLOCK, 32'd5, '0, 1'b0, '0, '0));
        queue_req(make_req(rrtt_pkg::REQ_UNBLOCK, '0, '0, 1'b0, '0, '0));
        queue_req(make_req(rrtt_pkg::REQ_DISPATCH, '0, '0, 1'b0, '0, '0));
        queue_req(make_req(rrtt_tb_pkg::REQ_RESERVED, 32'hFFFF_FFFF,
                           rrtt_tb_pkg::ST_BAD_CODE, 1'b1, '1, '1));
        for (int i = 0; i < 6; i++)
            queue_req(make_req(rrtt_pkg::REQ_REAP, '0, '0, 1'b0, '0, '0));

        // Random phases, each under its own reap_grace setting
        for (int ph = 0; ph < 8; ph++)
        begin
            pending_q.push_back(cfg_item(ph == 0 ? 3'd0 : ph == 1 ? 3'd7
                                          : 3'($urandom_range(0, 7))));
            for (int n = 0; n < NUM_RANDOM / 8; n++)
            begin
                k = $urandom_range(0, 99);
                t = k < 18 ? rrtt_pkg::REQ_CREATE : k < 32 ? rrtt_pkg::REQ_SET
                    : k < 52 ? rrtt_pkg::REQ_DISPATCH : k < 62 ? rrtt_pkg::REQ_REAP
                    : k < 74 ? rrtt_pkg::REQ_WAKE : k < 84 ? rrtt_pkg::REQ_UNBLOCK
                    : k < 98 ? rrtt_pkg::REQ_BLOCK : rrtt_tb_pkg::REQ_RESERVED;
                // id estimate uses the ids issued by creates the block has already taken
                queue_req(make_req(t, pick_id(), 3'($urandom_range(0, 7)),
                                   1'($urandom),
                                   $urandom_range(0, 3) == 0 ? rand48()
                                   : 48'($urandom_range(0, 1000)),
                                   $urandom_range(0, 3) == 0 ? rand48()
                                   : 48'($urandom_range(0, 1000))));
                if (ph == 7 && n > NUM_RANDOM / 16)
                    quiet = 1;
                // keep the queue short so pick_id sees live ids
                while (pending_q.size() > 4)
                    @(posedge clk);
            end
        end
        pending_q.push_back(cfg_item(rrtt_pkg::REAP_GRACE_RESET));
        queue_req(make_req(rrtt_pkg::REQ_REAP, '0, '0, 1'b0, '0, '0));

        while (pending_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
        repeat (4 * (SLOTS + 2)) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Reset: held low at start, then released
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Overall limit
    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
